// ----- hdl/edi_pkg.sv -----
// shared types, codes and field layout for the elevator door interlock
// no dependencies; imported by every module of the block

package edi_pkg;

  localparam int FLOORS  = 16;
  localparam int FLOOR_W = (FLOORS > 1) ? $clog2(FLOORS) : 1;

  localparam int REQ_W  = 3;
  localparam int IDX_W  = 4;
  localparam int OUTC_W = 3;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_OPEN    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_HOLD    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLOSE   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PRESS   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SET_BLK = 3'd5;

  // outcome codes
  localparam logic [OUTC_W-1:0] OUTC_FLAG    = 3'd0;
  localparam logic [OUTC_W-1:0] OUTC_OPENED  = 3'd1;
  localparam logic [OUTC_W-1:0] OUTC_HELD    = 3'd2;
  localparam logic [OUTC_W-1:0] OUTC_CLOSED  = 3'd3;
  localparam logic [OUTC_W-1:0] OUTC_ALREADY = 3'd4;
  localparam logic [OUTC_W-1:0] OUTC_REOPEN  = 3'd5;
  localparam logic [OUTC_W-1:0] OUTC_REFUSED = 3'd6;

  // door phase codes
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_OPENING = 2'd1;
  localparam logic [1:0] PH_HOLDING = 2'd2;
  localparam logic [1:0] PH_CLOSING = 2'd3;

  // config register indexes
  localparam int CIDX_W = 2;
  localparam logic [CIDX_W-1:0] CFG_OPEN_TIME  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_HOLD_TIME  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_CLOSE_TIME = 2'd2;

  // input tdata layout
  localparam int IN_TDATA_W = 16;
  localparam int IN_REQ_LSB = 0;
  localparam int IN_IDX_LSB = 3;
  localparam int IN_ALIGNED = 7;
  localparam int IN_PAUSED  = 8;
  localparam int IN_EMERG   = 9;
  localparam int IN_POFF    = 10;
  localparam int IN_FAULT   = 11;
  localparam int IN_OVER    = 12;
  localparam int IN_BLK     = 13;

  // output tdata layout
  localparam int OUT_TDATA_W  = 48;
  localparam int OUT_PH_LSB   = 0;
  localparam int OUT_OVERALL  = 2;
  localparam int OUT_CAR      = 3;
  localparam int OUT_LOPEN    = 4;
  localparam int OUT_LLOCK    = 5;
  localparam int OUT_ALLLOCK  = 6;
  localparam int OUT_TIME_LSB = 7;
  localparam int OUT_OUTC_LSB = 39;
  localparam int OUT_HELD     = 42;
  localparam int OUT_BLOCKED  = 43;

  // classified command passed from front to back
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [IDX_W-1:0] idx;
    logic             floor_ok;
    logic             aligned;
    logic             unsafe;
    logic             btn_ok;
    logic             blk;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic              overall_open;
    logic              car_open;
    logic              landing_open_here;
    logic              landing_locked_here;
    logic              all_locked;
    logic [TIME_W-1:0] total_time;
    logic [OUTC_W-1:0] outcome;
    logic              button_held;
    logic              door_blocked;
  } res_t;

endpackage

// ----- hdl/elevator_door_interlock.sv -----
// Elevator door interlock, top level.
// Input channel in_*: one door command item per handshake (tvalid & tready).
// Result channel out_*: exactly one status item per command, in order.
// Config channel cfg_*: writes open_time (0), hold_time (1), close_time (2);
//   cfg_ready is always high, indexes past the list are dropped.
// Path: an accepted item is written into the queue, then the back-end state
//   update loads the output register.
// Throughput: one item per cycle while out_tready is high; the back end updates
//   all door state and the saturating time adder for each item.
// A two-entry queue sits between front and back, so in_tready stays high
//   while a result waits; when out_tready is low the result holds and the
//   queue fills, then in_tready drops.
// Reset (rst_n low, synchronous): all landing doors closed and locked, car
//   and overall doors closed, phase idle, time zero, flags clear, config
//   registers back to 3/5/3, queue and output register empty.
// Built from edi_front, edi_queue and edi_back; uses edi_pkg.

module elevator_door_interlock
  import edi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // req_type[2:0], floor_index[6:3], aligned[7], admin_paused[8],
  // emergency_call[9], power_off[10], fault_active[11], overloaded[12],
  // blocked_value[13], zero[15:14]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // door_phase[1:0], overall_door_open[2], car_door_open[3],
  // landing_open_here[4], landing_locked_here[5], all_landing_locked[6],
  // total_time[38:7], outcome[41:39], button_held[42], door_blocked[43],
  // zero[47:44]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CIDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  cmd_t front_cmd, back_cmd;
  logic q_full, q_not_empty, q_pop;
  res_t res;

  assign cfg_ready = 1'b1;
  assign in_tready = ~q_full;

  edi_front u_front (
    .in_tdata (in_tdata),
    .cmd      (front_cmd)
  );

  edi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (back_cmd)
  );

  edi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (q_not_empty),
    .cmd       (back_cmd),
    .cmd_pop   (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  always_comb begin
    out_tdata = '0;
    out_tdata[OUT_PH_LSB +: 2]        = res.phase;
    out_tdata[OUT_OVERALL]            = res.overall_open;
    out_tdata[OUT_CAR]                = res.car_open;
    out_tdata[OUT_LOPEN]              = res.landing_open_here;
    out_tdata[OUT_LLOCK]              = res.landing_locked_here;
    out_tdata[OUT_ALLLOCK]            = res.all_locked;
    out_tdata[OUT_TIME_LSB +: TIME_W] = res.total_time;
    out_tdata[OUT_OUTC_LSB +: OUTC_W] = res.outcome;
    out_tdata[OUT_HELD]               = res.button_held;
    out_tdata[OUT_BLOCKED]            = res.door_blocked;
  end

endmodule

// ----- hdl/edi_front.sv -----
// front end: unpacks an input item and classifies its safety and floor checks
// uses edi_pkg; feeds edi_queue

module edi_front
  import edi_pkg::*;
(
  input  logic [IN_TDATA_W-1:0] in_tdata,
  output cmd_t                  cmd
);

  logic [IDX_W-1:0] idx;
  logic aligned, paused, emerg, poff, fault, over;

  assign idx     = in_tdata[IN_IDX_LSB +: IDX_W];
  assign aligned = in_tdata[IN_ALIGNED];
  assign paused  = in_tdata[IN_PAUSED];
  assign emerg   = in_tdata[IN_EMERG];
  assign poff    = in_tdata[IN_POFF];
  assign fault   = in_tdata[IN_FAULT];
  assign over    = in_tdata[IN_OVER];

  always_comb begin
    cmd.req      = in_tdata[IN_REQ_LSB +: REQ_W];
    cmd.idx      = idx;
    cmd.floor_ok = (32'(idx) < 32'(FLOORS));
    cmd.aligned  = aligned;
    cmd.unsafe   = paused | emerg | poff | fault | over | ~aligned;
    cmd.btn_ok   = ~poff & ~fault & aligned;
    cmd.blk      = in_tdata[IN_BLK];
  end

endmodule

// ----- hdl/edi_queue.sv -----
// two-entry command queue between the front and back ends
// uses edi_pkg for cmd_t

module edi_queue
  import edi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t pop_cmd
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- hdl/edi_back.sv -----
// back end: door state, config registers and the registered result
// uses edi_pkg; takes commands from edi_queue

module edi_back
  import edi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  logic [FLOORS-1:0] lopen_r, lopen_nxt;
  logic [FLOORS-1:0] llock_r, llock_nxt;
  logic              car_r, car_nxt;
  logic              overall_r, overall_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic              blocked_r, blocked_nxt;
  logic              held_r, held_nxt;
  logic [CFG_W-1:0]  open_time_r, hold_time_r, close_time_r;
  logic              res_valid_r;
  res_t              res_r, res_nxt;

  logic [FLOOR_W-1:0] fidx;
  logic [CFG_W:0]     add_amt;
  logic [TIME_W:0]    sum;
  logic               closed_here;
  logic [OUTC_W-1:0]  outc;

  assign cmd_pop   = cmd_valid & (~res_valid_r | res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign fidx      = FLOOR_W'(cmd.idx);

  always_comb begin
    lopen_nxt   = lopen_r;
    llock_nxt   = llock_r;
    car_nxt     = car_r;
    overall_nxt = overall_r;
    phase_nxt   = phase_r;
    blocked_nxt = blocked_r;
    held_nxt    = held_r;
    add_amt     = '0;
    outc        = OUTC_REFUSED;
    closed_here = ~overall_r & ~car_r & ~lopen_r[fidx] & llock_r[fidx];
    case (cmd.req)
      REQ_OPEN: begin
        if (cmd.floor_ok && cmd.aligned) begin
          phase_nxt       = PH_OPENING;
          llock_nxt[fidx] = 1'b0;
          lopen_nxt[fidx] = 1'b1;
          car_nxt         = 1'b1;
          overall_nxt     = 1'b1;
          add_amt         = (CFG_W+1)'(open_time_r);
          outc            = OUTC_OPENED;
        end
      end
      REQ_HOLD: begin
        phase_nxt   = PH_HOLDING;
        car_nxt     = 1'b1;
        overall_nxt = 1'b1;
        add_amt     = (CFG_W+1)'(hold_time_r);
        outc        = OUTC_HELD;
      end
      REQ_CLOSE: begin
        if (cmd.floor_ok) begin
          if (closed_here) begin
            outc = OUTC_ALREADY;
          end else if (cmd.unsafe || blocked_r || held_r) begin
            // reopen when aligned, then hold either way
            if (cmd.aligned) begin
              llock_nxt[fidx] = 1'b0;
              lopen_nxt[fidx] = 1'b1;
              add_amt = (CFG_W+1)'(open_time_r) + (CFG_W+1)'(hold_time_r);
            end else begin
              add_amt = (CFG_W+1)'(hold_time_r);
            end
            phase_nxt   = PH_HOLDING;
            car_nxt     = 1'b1;
            overall_nxt = 1'b1;
            outc        = OUTC_REOPEN;
          end else begin
            phase_nxt       = PH_CLOSING;
            lopen_nxt[fidx] = 1'b0;
            llock_nxt[fidx] = 1'b1;
            car_nxt         = 1'b0;
            overall_nxt     = 1'b0;
            add_amt         = (CFG_W+1)'(close_time_r);
            outc            = OUTC_CLOSED;
          end
        end
      end
      REQ_PRESS: begin
        held_nxt = 1'b1;
        if (cmd.btn_ok) begin
          if (cmd.floor_ok) begin
            llock_nxt[fidx] = 1'b0;
            lopen_nxt[fidx] = 1'b1;
            car_nxt         = 1'b1;
            overall_nxt     = 1'b1;
          end
          phase_nxt = PH_HOLDING;
        end
        outc = OUTC_FLAG;
      end
      REQ_RELEASE: begin
        held_nxt = 1'b0;
        outc     = OUTC_FLAG;
      end
      REQ_SET_BLK: begin
        blocked_nxt = cmd.blk;
        outc        = OUTC_FLAG;
      end
      default: begin
        outc = OUTC_REFUSED;
      end
    endcase

    // saturating add
    sum      = {1'b0, time_r} + (TIME_W+1)'(add_amt);
    time_nxt = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    res_nxt.phase               = phase_nxt;
    res_nxt.overall_open        = overall_nxt;
    res_nxt.car_open            = car_nxt;
    res_nxt.landing_open_here   = cmd.floor_ok & lopen_nxt[fidx];
    res_nxt.landing_locked_here = cmd.floor_ok & llock_nxt[fidx];
    res_nxt.all_locked          = ~(|lopen_nxt) & (&llock_nxt);
    res_nxt.total_time          = time_nxt;
    res_nxt.outcome             = outc;
    res_nxt.button_held         = held_nxt;
    res_nxt.door_blocked        = blocked_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lopen_r      <= '0;
      llock_r      <= '1;
      car_r        <= 1'b0;
      overall_r    <= 1'b0;
      phase_r      <= PH_IDLE;
      time_r       <= '0;
      blocked_r    <= 1'b0;
      held_r       <= 1'b0;
      open_time_r  <= CFG_W'(3);
      hold_time_r  <= CFG_W'(5);
      close_time_r <= CFG_W'(3);
      res_valid_r  <= 1'b0;
    end else begin
      if (cmd_pop) begin
        lopen_r   <= lopen_nxt;
        llock_r   <= llock_nxt;
        car_r     <= car_nxt;
        overall_r <= overall_nxt;
        phase_r   <= phase_nxt;
        time_r    <= time_nxt;
        blocked_r <= blocked_nxt;
        held_r    <= held_nxt;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_OPEN_TIME:  open_time_r  <= cfg_data;
          CFG_HOLD_TIME:  hold_time_r  <= cfg_data;
          CFG_CLOSE_TIME: close_time_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd_pop) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/edi_checker.sv -----
// port-level checks on the interlock result channel, bound to the top level
// uses edi_pkg for the output field layout

module edi_checker
  import edi_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [OUTC_W-1:0] outc;
  logic [1:0]        ph;

  assign outc = out_tdata[OUT_OUTC_LSB +: OUTC_W];
  assign ph   = out_tdata[OUT_PH_LSB +: 2];

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a successful close leaves everything shut at the closing phase
  a_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && outc == OUTC_CLOSED |->
      ph == PH_CLOSING && !out_tdata[OUT_CAR] && !out_tdata[OUT_OVERALL]
      && !out_tdata[OUT_LOPEN] && out_tdata[OUT_LLOCK])
    else $error("closed outcome with doors not shut");

  // open, hold and refused close all leave the car door open
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (outc == OUTC_OPENED || outc == OUTC_HELD || outc == OUTC_REOPEN)
      |-> out_tdata[OUT_CAR] && out_tdata[OUT_OVERALL])
    else $error("open outcome with car door shut");

  // all locked excludes an open landing door here
  a_alllock: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_ALLLOCK] |-> !out_tdata[OUT_LOPEN])
    else $error("all locked while this landing door is open");

endmodule

bind elevator_door_interlock edi_checker u_edi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
